[rtl/lcdx_pkg.sv]
// Shared types and constants for the character-LCD expander writer.
`timescale 1ns / 1ps

package lcdx_pkg;

   // Request kinds.
   localparam logic [2:0] KIND_COMMAND = 3'd0;
   localparam logic [2:0] KIND_DATA    = 3'd1;
   localparam logic [2:0] KIND_CHAR_AT = 3'd2;
   localparam logic [2:0] KIND_GLYPH   = 3'd3;
   localparam logic [2:0] KIND_CLEAR   = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ROW_COUNT      = 2'd0;
   localparam logic [1:0] CSR_COLUMN_COUNT   = 2'd1;
   localparam logic [1:0] CSR_DEVICE_ADDRESS = 2'd2;

   // Register reset values.
   localparam logic [2:0] ROW_COUNT_RESET      = 3'd4;
   localparam logic [5:0] COLUMN_COUNT_RESET   = 6'd20;
   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd39;

   // LCD instruction bits.
   localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
   localparam logic [7:0] LCD_SET_CGRAM  = 8'h40;
   localparam logic [7:0] LCD_CLEAR      = 8'h01;
   localparam logic [7:0] LCD_ROW_ODD    = 8'h40;

   // Number of pattern bytes in one glyph.
   localparam logic [3:0] GLYPH_ROWS = 4'd8;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  value;
      logic [1:0]  row;
      logic [5:0]  column;
      logic [63:0] glyph_pattern;
   } req_type;

   typedef struct packed {
      logic [7:0] expander_byte;
      logic [6:0] bus_address;
      logic       wait_after;
      logic       last;
   } rsp_type;

   // One job for the back end: a leading LCD byte plus up to eight data bytes.
   typedef struct packed {
      logic [7:0]  first_byte;
      logic        first_rs;
      logic [3:0]  tail_count;
      logic [63:0] tail_data;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/lcdx_front.sv]
// Front end: checks and classifies a request into a job for the back end.
`timescale 1ns / 1ps

module lcdx_front #(
   parameter int MAX_ROW_COUNT    = 4,
   parameter int MAX_COLUMN_COUNT = 40
) (
   input  lcdx_pkg::req_type req,
   input  logic [2:0]        row_count,
   input  logic [5:0]        column_count,
   output logic              job_ok,
   output lcdx_pkg::job_type job
);
   import lcdx_pkg::*;

   logic [2:0] eff_rows;
   logic [5:0] eff_cols;
   logic       pos_ok;
   logic [7:0] ddram_addr;

   always_comb begin
      eff_rows = (row_count > 3'(MAX_ROW_COUNT)) ? 3'(MAX_ROW_COUNT) : row_count;
      eff_cols = (column_count > 6'(MAX_COLUMN_COUNT)) ? 6'(MAX_COLUMN_COUNT) : column_count;
      pos_ok   = ({1'b0, req.row} < eff_rows) && (req.column < eff_cols);
      // Two 40-wide lines are split into four rows.
      ddram_addr = {2'b00, req.column}
                 + (req.row[0] ? LCD_ROW_ODD : 8'h00)
                 + (req.row[1] ? {2'b00, eff_cols} : 8'h00);
   end

   always_comb begin
      job_ok         = 1'b0;
      job.first_byte = req.value;
      job.first_rs   = 1'b0;
      job.tail_count = 4'd0;
      job.tail_data  = req.glyph_pattern;
      case (req.kind)
         KIND_COMMAND: begin
            job_ok = 1'b1;
         end
         KIND_DATA: begin
            job_ok       = 1'b1;
            job.first_rs = 1'b1;
         end
         KIND_CHAR_AT: begin
            job_ok         = pos_ok;
            job.first_byte = LCD_SET_DDRAM | ddram_addr;
            job.tail_count = 4'd1;
            job.tail_data  = {req.value, 56'd0};
         end
         KIND_GLYPH: begin
            job_ok         = (req.value[7:3] == 5'd0);
            job.first_byte = LCD_SET_CGRAM | {2'b00, req.value[2:0], 3'b000};
            job.tail_count = GLYPH_ROWS;
         end
         KIND_CLEAR: begin
            job_ok         = 1'b1;
            job.first_byte = LCD_CLEAR;
         end
         default: begin
            job_ok = 1'b0;
         end
      endcase
   end

endmodule

[rtl/lcdx_queue.sv]
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps

module lcdx_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  lcdx_pkg::job_type          push_job,
   input  logic                       pop,
   output lcdx_pkg::job_type          head_job,
   output lcdx_pkg::queue_status_type status
);
   import lcdx_pkg::*;

   job_type    slot_ff [2];
   job_type    slot_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = push_job;
         wr_ptr_in          = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head_job     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule

[rtl/lcdx_back.sv]
// Back end: expands each job into expander bytes, four per LCD byte.
`timescale 1ns / 1ps

module lcdx_back (
   input  logic                       clock,
   input  logic                       reset,
   input  lcdx_pkg::job_type          head_job,
   input  lcdx_pkg::queue_status_type status,
   input  logic [6:0]                 device_address,
   output logic                       pop,
   output logic                       rsp_valid,
   output lcdx_pkg::rsp_type          rsp
);
   import lcdx_pkg::*;

   logic        active_ff, active_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  byte_ff, byte_in;
   logic        rs_ff, rs_in;
   logic [3:0]  rem_ff, rem_in;
   logic [63:0] tail_ff, tail_in;
   logic        valid_ff, valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        finishing;
   logic [3:0]  nibble;

   assign finishing = active_ff && (phase_ff == 2'd3) && (rem_ff == 4'd0);
   assign pop       = !status.empty && (!active_ff || finishing);

   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      byte_in   = byte_ff;
      rs_in     = rs_ff;
      rem_in    = rem_ff;
      tail_in   = tail_ff;
      if (pop) begin
         active_in = 1'b1;
         phase_in  = 2'd0;
         byte_in   = head_job.first_byte;
         rs_in     = head_job.first_rs;
         rem_in    = head_job.tail_count;
         tail_in   = head_job.tail_data;
      end else if (finishing) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         phase_in = phase_ff + 2'd1;
         if (phase_ff == 2'd3) begin
            // Next LCD byte comes from the top of the tail; all tail bytes are data.
            byte_in = tail_ff[63:56];
            tail_in = {tail_ff[55:0], 8'h00};
            rem_in  = rem_ff - 4'd1;
            rs_in   = 1'b1;
         end
      end
   end

   always_comb begin
      nibble               = phase_ff[1] ? byte_ff[3:0] : byte_ff[7:4];
      valid_in             = active_ff;
      rsp_in.expander_byte = {nibble, 1'b1, ~phase_ff[0], 1'b0, rs_ff};
      rsp_in.bus_address   = device_address;
      rsp_in.wait_after    = phase_ff[0];
      rsp_in.last          = finishing;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rs_ff   <= rs_in;
      rem_ff  <= rem_in;
      tail_ff <= tail_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= 2'd0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/char_lcd_nibble_expander_writer_top.sv]
// Top level of the character-LCD writer for an I2C port expander.
`timescale 1ns / 1ps

// Channel        Ports                                   Direction  Handshake
// request        start, busy, req                        in         start && !busy
// response       rsp_valid, rsp                          out        valid only, no ready
// configuration  csr_valid, csr_ready, csr_index, csr_data in       csr_valid && csr_ready
//
// Each LCD byte becomes four expander bytes, one per cycle. A command, data
// or clear item is one LCD byte, a positioned character two and a glyph load
// nine: the leading byte and then the tail bytes.
// A two-entry job queue lets the front end take new items while the back end
// works; busy is high only while that queue is full. Rejected items give no
// output and never enter the queue. Reset is synchronous and restores the
// register defaults; the receiver cannot stall, so results never wait.

module char_lcd_nibble_expander_writer_top #(
   parameter int MAX_ROW_COUNT    = 4,
   parameter int MAX_COLUMN_COUNT = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lcdx_pkg::req_type req,
   output logic              rsp_valid,
   output lcdx_pkg::rsp_type rsp,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_data
);
   import lcdx_pkg::*;

   logic [2:0] row_count_ff, row_count_in;
   logic [5:0] column_count_ff, column_count_in;
   logic [6:0] device_address_ff, device_address_in;

   logic             job_ok;
   job_type          front_job;
   job_type          head_job;
   logic             push;
   logic             pop;
   queue_status_type status;

   // Registers are always writable; writes beyond the list are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      row_count_in      = row_count_ff;
      column_count_in   = column_count_ff;
      device_address_in = device_address_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROW_COUNT:      row_count_in      = csr_data[2:0];
            CSR_COLUMN_COUNT:   column_count_in   = csr_data[5:0];
            CSR_DEVICE_ADDRESS: device_address_in = csr_data;
            default:            row_count_in      = row_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff      <= ROW_COUNT_RESET;
         column_count_ff   <= COLUMN_COUNT_RESET;
         device_address_ff <= DEVICE_ADDRESS_RESET;
      end else begin
         row_count_ff      <= row_count_in;
         column_count_ff   <= column_count_in;
         device_address_ff <= device_address_in;
      end
   end

   // An item is taken whenever the queue has room; only valid jobs are queued.
   assign busy = status.full;
   assign push = start && !busy && job_ok;

   lcdx_front #(
      .MAX_ROW_COUNT    (MAX_ROW_COUNT),
      .MAX_COLUMN_COUNT (MAX_COLUMN_COUNT)
   ) u_front (
      .req          (req),
      .row_count    (row_count_ff),
      .column_count (column_count_ff),
      .job_ok       (job_ok),
      .job          (front_job)
   );

   lcdx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (front_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (status)
   );

   lcdx_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .status         (status),
      .device_address (device_address_ff),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp            (rsp)
   );

endmodule
